// ===== sv/kwhm_pkg.sv =====
// Shared types, widths and codes for the k-way merge engine.
// No dependencies; every other file imports this package.
`default_nettype none

package kwhm_pkg;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;

    localparam int DATA_W      = 32;
    localparam int LIST_W      = 3;
    localparam int KIND_W      = 1;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [KIND_W-1:0] KIND_APPEND = 1'b0;
    localparam logic [KIND_W-1:0] KIND_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic                     append;
        logic [LIST_W-1:0]        list_index;
        logic [DATA_W-1:0]        value;
    } kwhm_cmd_t;

endpackage

`default_nettype wire

// ===== sv/k_way_heap_merge_engine_top.sv =====
// Top level of the k-way merge engine: stream ports, control sequencer and
// the chain of list cells. Depends on kwhm_pkg and kwhm_cell.
//
//  channel | direction | tdata (low bit up)               | tuser
//  s_      | in        | list_index[2:0], value[31:0]     | kind
//  m_      | out       | out_value[31:0], from_list[2:0]  | status[1:0]
//
// Append: accept, then output load; no new item is taken until the result loads.
// Pop: the minimum travels one cell per cycle down the chain, then the winning
// list advances its read pointer.
// Reset clears all pointers; the queue memories are not cleared.
// A held result on m_ blocks the sequencer until taken; s_tready drops meanwhile.
`default_nettype none

module k_way_heap_merge_engine_top #(
    parameter int NUM_LISTS  = kwhm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwhm_pkg::LIST_DEPTH_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // list_index[2:0], value[34:3], zero pad [39:35]
    input  wire [kwhm_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  wire [kwhm_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out_value[31:0], from_list[34:32], zero pad [39:35]
    output logic [kwhm_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [kwhm_pkg::STATUS_W-1:0]   m_tuser
);
    import kwhm_pkg::*;

    localparam int IDX_W = $clog2(NUM_LISTS);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SWEEP   = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_value_reg,  res_value_next;
    logic [LIST_W-1:0]   res_from_reg,   res_from_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [DATA_W-1:0]   m_value_reg;
    logic [LIST_W-1:0]   m_from_reg;

    logic                s_xfer;
    logic                pop_start;
    logic                sweep_done;
    logic                out_load;
    kwhm_cmd_t           cmd;

    logic                go_w    [NUM_LISTS+1];
    logic                found_w [NUM_LISTS+1];
    logic [DATA_W-1:0]   val_w   [NUM_LISTS+1];
    logic [IDX_W-1:0]    idx_w   [NUM_LISTS+1];

    logic [NUM_LISTS-1:0] hit_vec;
    logic [NUM_LISTS-1:0] nonempty_vec;
    logic [NUM_LISTS-1:0] go_vec;
    logic [NUM_LISTS-1:0] commit_vec;

    logic [IDX_W+LIST_W-1:0] win_wide;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign pop_start  = s_xfer && (s_tuser == KIND_POP);
    assign sweep_done = (state_reg == ST_SWEEP) && go_w[NUM_LISTS];
    assign out_load   = (state_reg == ST_DELIVER) && (!m_valid_reg || m_tready);
    assign win_wide   = {{LIST_W{1'b0}}, idx_w[NUM_LISTS]};

    assign cmd.append     = s_xfer && (s_tuser == KIND_APPEND);
    assign cmd.list_index = s_tdata[LIST_W-1:0];
    assign cmd.value      = s_tdata[LIST_W+DATA_W-1:LIST_W];

    assign go_w[0]    = pop_start;
    assign found_w[0] = 1'b0;
    assign val_w[0]   = '0;
    assign idx_w[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_LISTS; gi++) begin : g_cell
            assign go_vec[gi]     = go_w[gi+1];
            assign commit_vec[gi] = sweep_done && found_w[NUM_LISTS] &&
                                    (idx_w[NUM_LISTS] == IDX_W'(gi));

            kwhm_cell #(
                .NUM_LISTS  (NUM_LISTS),
                .LIST_DEPTH (LIST_DEPTH),
                .CELL_IDX   (gi),
                .IDX_W      (IDX_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .commit    (commit_vec[gi]),
                .go_in     (go_w[gi]),
                .found_in  (found_w[gi]),
                .val_in    (val_w[gi]),
                .idx_in    (idx_w[gi]),
                .go_out    (go_w[gi+1]),
                .found_out (found_w[gi+1]),
                .val_out   (val_w[gi+1]),
                .idx_out   (idx_w[gi+1]),
                .hit       (hit_vec[gi]),
                .nonempty  (nonempty_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_from_next   = res_from_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_start) begin
                    state_next = ST_SWEEP;
                end else if (s_xfer) begin
                    state_next      = ST_DELIVER;
                    res_status_next = (|hit_vec) ? STATUS_APPENDED : STATUS_FULL;
                    res_value_next  = '0;
                    res_from_next   = '0;
                end
            end
            ST_SWEEP: begin
                if (go_w[NUM_LISTS]) begin
                    state_next = ST_DELIVER;
                    if (found_w[NUM_LISTS]) begin
                        res_status_next = STATUS_POPPED;
                        res_value_next  = val_w[NUM_LISTS];
                        res_from_next   = win_wide[LIST_W-1:0];
                    end else begin
                        res_status_next = STATUS_EMPTY;
                        res_value_next  = '0;
                        res_from_next   = '0;
                    end
                end
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_from_reg   <= res_from_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_value_reg  <= res_value_reg;
            m_from_reg   <= res_from_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-LIST_W){1'b0}}, m_from_reg, m_value_reg};

`ifndef ASSERT_OFF
    a_sweep_token_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> $onehot(go_vec))
        else $error("sweep token lost or duplicated");

    a_no_token_outside_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SWEEP) |-> (go_vec == '0))
        else $error("sweep token outside sweep");

    a_pop_needs_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (sweep_done && found_w[NUM_LISTS]) |-> (|nonempty_vec))
        else $error("pop winner found with all lists empty");

    a_single_append_target: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("append matches more than one list");
`endif

endmodule

`default_nettype wire

// ===== sv/kwhm_cell.sv =====
// One list of the merge engine: bounded queue memory, pointers, head register,
// and one stage of the minimum-search chain. Depends on kwhm_pkg.
`default_nettype none

module kwhm_cell #(
    parameter int NUM_LISTS  = kwhm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwhm_pkg::LIST_DEPTH_DEF,
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = $clog2(NUM_LISTS)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  kwhm_pkg::kwhm_cmd_t          cmd,
    input  wire                          commit,
    input  wire                          go_in,
    input  wire                          found_in,
    input  wire [kwhm_pkg::DATA_W-1:0]   val_in,
    input  wire [IDX_W-1:0]              idx_in,
    output logic                         go_out,
    output logic                         found_out,
    output logic [kwhm_pkg::DATA_W-1:0]  val_out,
    output logic [IDX_W-1:0]             idx_out,
    output logic                         hit,
    output logic                         nonempty
);
    import kwhm_pkg::*;

    localparam int SLOT_W = $clog2(LIST_DEPTH);
    localparam int CMP_W  = LIST_W + IDX_W;

    logic [DATA_W-1:0] mem [LIST_DEPTH];
    logic [DATA_W-1:0] head_reg;

    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              rd_wrap_reg, rd_wrap_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic              wr_wrap_reg, wr_wrap_next;

    logic              go_reg;
    logic              found_reg;
    logic [DATA_W-1:0] val_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              full;
    logic              match;
    logic              take;
    logic              wr_en;

    assign nonempty = (rd_slot_reg != wr_slot_reg) || (rd_wrap_reg != wr_wrap_reg);
    assign full     = (rd_slot_reg == wr_slot_reg) && (rd_wrap_reg != wr_wrap_reg);
    assign match    = ({{IDX_W{1'b0}}, cmd.list_index} == CMP_W'(CELL_IDX));
    assign hit      = match && !full;
    assign wr_en    = cmd.append && hit;
    assign take     = nonempty && (!found_in || ($signed(head_reg) < $signed(val_in)));

    always_comb begin
        wr_slot_next = wr_slot_reg;
        wr_wrap_next = wr_wrap_reg;
        if (wr_en) begin
            if (wr_slot_reg == SLOT_W'(LIST_DEPTH - 1)) begin
                wr_slot_next = '0;
                wr_wrap_next = !wr_wrap_reg;
            end else begin
                wr_slot_next = wr_slot_reg + 1'b1;
            end
        end
    end

    always_comb begin
        rd_slot_next = rd_slot_reg;
        rd_wrap_next = rd_wrap_reg;
        if (commit) begin
            if (rd_slot_reg == SLOT_W'(LIST_DEPTH - 1)) begin
                rd_slot_next = '0;
                rd_wrap_next = !rd_wrap_reg;
            end else begin
                rd_slot_next = rd_slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_slot_reg <= '0;
            rd_wrap_reg <= 1'b0;
            wr_slot_reg <= '0;
            wr_wrap_reg <= 1'b0;
            go_reg      <= 1'b0;
        end else begin
            rd_slot_reg <= rd_slot_next;
            rd_wrap_reg <= rd_wrap_next;
            wr_slot_reg <= wr_slot_next;
            wr_wrap_reg <= wr_wrap_next;
            go_reg      <= go_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot_reg] <= cmd.value;
        end
        head_reg <= mem[rd_slot_reg];
    end

    // advance the running minimum; strict compare keeps the lower list on ties
    always_ff @(posedge aclk) begin
        if (take) begin
            found_reg <= 1'b1;
            val_reg   <= head_reg;
            idx_reg   <= IDX_W'(CELL_IDX);
        end else begin
            found_reg <= found_in;
            val_reg   <= val_in;
            idx_reg   <= idx_in;
        end
    end

    assign go_out    = go_reg;
    assign found_out = found_reg;
    assign val_out   = val_reg;
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire
